/* sv/rqsr_pkg.sv */
// ----------------------------------------------------------------------------
// rqsr_pkg
// Shared types, command and status codes for the ring queue slot sequencer.
// ----------------------------------------------------------------------------
package rqsr_pkg;

    // Default sizing
    localparam int DEFAULT_CAPACITY = 16;
    localparam int DEFAULT_GEN_BITS = 8;

    // Fixed field widths of the command and response channels
    typedef logic [2:0] cmd_t;
    typedef logic [7:0] gen_field_t;
    typedef logic [3:0] slot_field_t;
    typedef logic [2:0] status_t;
    typedef logic [4:0] length_t;
    typedef logic [1:0] phase_t;

    // Commands
    localparam cmd_t CMD_RESERVE_PUSH = 3'd0;
    localparam cmd_t CMD_COMMIT_PUSH  = 3'd1;
    localparam cmd_t CMD_RESERVE_POP  = 3'd2;
    localparam cmd_t CMD_COMMIT_POP   = 3'd3;
    localparam cmd_t CMD_CLEAR_STEP   = 3'd4;
    localparam cmd_t CMD_ABORT_PUSH   = 3'd5;
    localparam cmd_t CMD_DISABLE      = 3'd6;
    localparam cmd_t CMD_ENABLE       = 3'd7;

    // Response status
    localparam status_t STS_OK       = 3'd0;
    localparam status_t STS_FULL     = 3'd1;
    localparam status_t STS_EMPTY    = 3'd2;
    localparam status_t STS_DISABLED = 3'd3;
    localparam status_t STS_BUSY     = 3'd4;
    localparam status_t STS_END      = 3'd5;
    localparam status_t STS_SKIP     = 3'd6;

    // Slot phases; EMPTY must be zero, the clearing pass writes all zeros
    localparam phase_t PH_EMPTY   = 2'd0;
    localparam phase_t PH_WRITING = 2'd1;
    localparam phase_t PH_FULL    = 2'd2;
    localparam phase_t PH_READING = 2'd3;

endpackage

/* sv/rqsr_cmd_if.sv */
// ----------------------------------------------------------------------------
// rqsr_cmd_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface rqsr_cmd_if;

    logic                     valid;
    logic                     ready;
    rqsr_pkg::cmd_t           command;
    rqsr_pkg::gen_field_t     generation;
    rqsr_pkg::slot_field_t    slot_index;

    modport source (
        output valid,
        output command,
        output generation,
        output slot_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  generation,
        input  slot_index,
        output ready
    );

endinterface

/* sv/rqsr_rsp_if.sv */
// ----------------------------------------------------------------------------
// rqsr_rsp_if
// Response channel: valid/ready handshake with the response payload.
// ----------------------------------------------------------------------------
interface rqsr_rsp_if;

    logic                     valid;
    logic                     ready;
    rqsr_pkg::status_t        status;
    rqsr_pkg::gen_field_t     granted_generation;
    rqsr_pkg::slot_field_t    granted_slot;
    rqsr_pkg::length_t        length;
    logic                     enabled;

    modport source (
        output valid,
        output status,
        output granted_generation,
        output granted_slot,
        output length,
        output enabled,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  granted_generation,
        input  granted_slot,
        input  length,
        input  enabled,
        output ready
    );

endinterface

/* sv/rqsr_slot_store.sv */
// ----------------------------------------------------------------------------
// rqsr_slot_store
// Per-slot phase/generation memory, one read and one write port, registered
// read data. Runs a clearing pass after reset and flags when it is done.
// ----------------------------------------------------------------------------
module rqsr_slot_store #(
    parameter int DEPTH  = rqsr_pkg::DEFAULT_CAPACITY,
    parameter int WIDTH  = rqsr_pkg::DEFAULT_GEN_BITS + 2,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    output logic              init_done
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [WIDTH-1:0]  slot_mem_reg [DEPTH];
    logic [WIDTH-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clr_done_reg;
    logic              clr_done_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WIDTH-1:0]  mem_wdata;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_done_reg <= clr_done_next;
        end
    end

    // clearing pass owns the write port until it finishes
    assign mem_we    = !clr_done_reg || wr_en;
    assign mem_waddr = clr_done_reg ? wr_addr : clr_addr_reg;
    assign mem_wdata = clr_done_reg ? wr_data : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem_reg[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem_reg[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_done = clr_done_reg;

endmodule

/* sv/ring_queue_slot_reservation_unit.sv */
// ----------------------------------------------------------------------------
// ring_queue_slot_reservation_unit
// Slot sequencer for a bounded ring queue. Each accepted command produces
// exactly one response. The transfer cycle issues the read of one slot entry
// from the synchronous slot memory; on the registered read data the command
// is then evaluated, the entry written back and the response register loaded,
// held off while the response register is still held by the consumer. After
// reset, a clearing pass writes every slot entry to empty/generation zero,
// during which no command is taken.
// ----------------------------------------------------------------------------
module ring_queue_slot_reservation_unit #(
    parameter int CAPACITY = rqsr_pkg::DEFAULT_CAPACITY,
    parameter int GEN_BITS = rqsr_pkg::DEFAULT_GEN_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    rqsr_cmd_if.sink     cmd,
    rqsr_rsp_if.source   rsp
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int ENTRY_W = GEN_BITS + 2;

    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [GEN_BITS-1:0] gen_t;
    typedef logic [SLOT_W:0]     len_t;

    localparam slot_t SLOT_LAST = SLOT_W'(CAPACITY - 1);
    localparam len_t  CAP_LEN   = (SLOT_W + 1)'(CAPACITY);
    localparam gen_t  GEN_ONE   = GEN_BITS'(1);

    localparam logic FSM_IDLE = 1'b0;
    localparam logic FSM_EXEC = 1'b1;

    // control
    logic                 state_reg;
    logic                 state_next;
    logic                 init_done;
    logic                 cmd_fire;
    logic                 exec_fire;

    // captured command
    rqsr_pkg::cmd_t       cmd_reg;
    gen_t                 gin_reg;
    slot_t                sin_reg;
    logic                 sin_ok_reg;

    // positions and flag
    slot_t                push_slot_reg;
    gen_t                 push_gen_reg;
    slot_t                pop_slot_reg;
    gen_t                 pop_gen_reg;
    logic                 disabled_reg;
    slot_t                push_slot_next;
    gen_t                 push_gen_next;
    slot_t                pop_slot_next;
    gen_t                 pop_gen_next;
    logic                 disabled_next;
    logic                 push_adv;
    logic                 pop_adv;

    // memory port
    slot_t                rd_addr;
    slot_t                addr_reg;     // write-back address is the entry read for this command
    logic [ENTRY_W-1:0]   rd_data;
    logic                 wr_req;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_data;
    rqsr_pkg::phase_t     ph;
    gen_t                 sg;
    rqsr_pkg::phase_t     new_ph;
    gen_t                 new_gen;
    gen_t                 push_diff;
    gen_t                 pop_diff;

    // response
    rqsr_pkg::status_t    sts;
    gen_t                 grant_gen;
    slot_t                grant_slot;
    logic                 out_valid_reg;
    rqsr_pkg::status_t    status_reg;
    rqsr_pkg::gen_field_t ggen_reg;
    rqsr_pkg::slot_field_t gslot_reg;
    rqsr_pkg::length_t    length_reg;
    logic                 enabled_reg;

    // length
    len_t                 sdiff;
    len_t                 sdiff_wrap;
    slot_t                sd;
    gen_t                 gd;
    len_t                 len_full;

    rqsr_slot_store #(
        .DEPTH  (CAPACITY),
        .WIDTH  (ENTRY_W),
        .ADDR_W (SLOT_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (cmd_fire),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (addr_reg),
        .wr_data   (wr_data),
        .init_done (init_done)
    );

    assign cmd.ready = (state_reg == FSM_IDLE) && init_done;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign exec_fire = (state_reg == FSM_EXEC) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        unique case (cmd.command)
            rqsr_pkg::CMD_RESERVE_PUSH: rd_addr = push_slot_reg;
            rqsr_pkg::CMD_RESERVE_POP,
            rqsr_pkg::CMD_CLEAR_STEP:   rd_addr = pop_slot_reg;
            rqsr_pkg::CMD_COMMIT_PUSH,
            rqsr_pkg::CMD_COMMIT_POP,
            rqsr_pkg::CMD_ABORT_PUSH,
            rqsr_pkg::CMD_DISABLE,
            rqsr_pkg::CMD_ENABLE:       rd_addr = SLOT_W'(cmd.slot_index);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            gin_reg    <= GEN_BITS'(cmd.generation);
            sin_reg    <= SLOT_W'(cmd.slot_index);
            sin_ok_reg <= 32'(cmd.slot_index) < 32'(CAPACITY);
            addr_reg   <= rd_addr;
        end
    end

    assign ph        = rd_data[ENTRY_W-1:GEN_BITS];
    assign sg        = rd_data[GEN_BITS-1:0];
    assign push_diff = push_gen_reg - sg;
    assign pop_diff  = pop_gen_reg - sg;

    // command evaluation on the entry just read
    always_comb
    begin
        sts           = rqsr_pkg::STS_BUSY;
        grant_gen     = '0;
        grant_slot    = '0;
        wr_req        = 1'b0;
        new_ph        = ph;
        new_gen       = sg;
        push_adv      = 1'b0;
        pop_adv       = 1'b0;
        disabled_next = disabled_reg;
        unique case (cmd_reg)
            rqsr_pkg::CMD_RESERVE_PUSH:
            begin
                if (disabled_reg)
                begin
                    sts = rqsr_pkg::STS_DISABLED;
                end
                else if (ph == rqsr_pkg::PH_EMPTY && sg == push_gen_reg)
                begin
                    sts        = rqsr_pkg::STS_OK;
                    grant_gen  = push_gen_reg;
                    grant_slot = push_slot_reg;
                    wr_req     = 1'b1;
                    new_ph     = rqsr_pkg::PH_WRITING;
                    push_adv   = 1'b1;
                end
                else if (push_diff == GEN_ONE)
                begin
                    sts = (ph == rqsr_pkg::PH_READING) ? rqsr_pkg::STS_BUSY
                                                       : rqsr_pkg::STS_FULL;
                end
                else
                begin
                    push_adv = 1'b1;
                end
            end
            rqsr_pkg::CMD_COMMIT_PUSH:
            begin
                if (sin_ok_reg && ph == rqsr_pkg::PH_WRITING && sg == gin_reg)
                begin
                    sts    = rqsr_pkg::STS_OK;
                    wr_req = 1'b1;
                    new_ph = rqsr_pkg::PH_FULL;
                end
            end
            rqsr_pkg::CMD_RESERVE_POP:
            begin
                if (ph == rqsr_pkg::PH_FULL && sg == pop_gen_reg)
                begin
                    sts        = rqsr_pkg::STS_OK;
                    grant_gen  = pop_gen_reg;
                    grant_slot = pop_slot_reg;
                    wr_req     = 1'b1;
                    new_ph     = rqsr_pkg::PH_READING;
                    pop_adv    = 1'b1;
                end
                else if (pop_diff == GEN_ONE ||
                         (pop_diff == '0 && ph == rqsr_pkg::PH_EMPTY))
                begin
                    sts = rqsr_pkg::STS_EMPTY;
                end
                else if (pop_diff == '0 && ph != rqsr_pkg::PH_WRITING)
                begin
                    // slot already being read: step past it
                    pop_adv = 1'b1;
                end
            end
            rqsr_pkg::CMD_COMMIT_POP:
            begin
                if (sin_ok_reg && ph == rqsr_pkg::PH_READING && sg == gin_reg)
                begin
                    sts     = rqsr_pkg::STS_OK;
                    wr_req  = 1'b1;
                    new_ph  = rqsr_pkg::PH_EMPTY;
                    new_gen = gin_reg + GEN_ONE;
                end
            end
            rqsr_pkg::CMD_CLEAR_STEP:
            begin
                if (!sin_ok_reg || (gin_reg == pop_gen_reg && sin_reg == pop_slot_reg))
                begin
                    sts = rqsr_pkg::STS_END;
                end
                else if (ph == rqsr_pkg::PH_FULL && sg == pop_gen_reg)
                begin
                    sts        = rqsr_pkg::STS_OK;
                    grant_gen  = pop_gen_reg;
                    grant_slot = pop_slot_reg;
                    wr_req     = 1'b1;
                    new_ph     = rqsr_pkg::PH_READING;
                    pop_adv    = 1'b1;
                end
                else if (ph == rqsr_pkg::PH_WRITING || ph == rqsr_pkg::PH_FULL)
                begin
                    sts = rqsr_pkg::STS_BUSY;
                end
                else
                begin
                    sts     = rqsr_pkg::STS_SKIP;
                    pop_adv = 1'b1;
                end
            end
            rqsr_pkg::CMD_ABORT_PUSH:
            begin
                if (sin_ok_reg && ph == rqsr_pkg::PH_WRITING && sg == gin_reg &&
                    pop_gen_reg == gin_reg && pop_slot_reg == sin_reg)
                begin
                    sts     = rqsr_pkg::STS_OK;
                    wr_req  = 1'b1;
                    new_ph  = rqsr_pkg::PH_EMPTY;
                    new_gen = gin_reg + GEN_ONE;
                    pop_adv = 1'b1;
                end
            end
            rqsr_pkg::CMD_DISABLE:
            begin
                sts           = rqsr_pkg::STS_OK;
                disabled_next = 1'b1;
            end
            rqsr_pkg::CMD_ENABLE:
            begin
                sts           = rqsr_pkg::STS_OK;
                disabled_next = 1'b0;
            end
        endcase
    end

    assign wr_en   = exec_fire && wr_req;
    assign wr_data = {new_ph, new_gen};

    // position increments wrap the slot and carry into the generation
    always_comb
    begin
        push_slot_next = push_slot_reg;
        push_gen_next  = push_gen_reg;
        pop_slot_next  = pop_slot_reg;
        pop_gen_next   = pop_gen_reg;
        if (push_adv)
        begin
            if (push_slot_reg == SLOT_LAST)
            begin
                push_slot_next = '0;
                push_gen_next  = push_gen_reg + GEN_ONE;
            end
            else
            begin
                push_slot_next = push_slot_reg + SLOT_W'(1);
            end
        end
        if (pop_adv)
        begin
            if (pop_slot_reg == SLOT_LAST)
            begin
                pop_slot_next = '0;
                pop_gen_next  = pop_gen_reg + GEN_ONE;
            end
            else
            begin
                pop_slot_next = pop_slot_reg + SLOT_W'(1);
            end
        end
    end

    // circular distance push - pop in (generation, slot) form, then clamp
    always_comb
    begin
        sdiff      = {1'b0, push_slot_next} - {1'b0, pop_slot_next};
        sdiff_wrap = sdiff + CAP_LEN;
        sd         = sdiff[SLOT_W] ? sdiff_wrap[SLOT_W-1:0] : sdiff[SLOT_W-1:0];
        gd         = push_gen_next - pop_gen_next - GEN_BITS'(sdiff[SLOT_W]);
        priority if (gd[GEN_BITS-1] && (gd[GEN_BITS-2:0] != '0 || sd != '0))
        begin
            len_full = '0;
        end
        else if (gd == '0)
        begin
            len_full = {1'b0, sd};
        end
        else
        begin
            len_full = CAP_LEN;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: if (cmd_fire)  state_next = FSM_EXEC;
            FSM_EXEC: if (exec_fire) state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cmd_reg       <= rqsr_pkg::CMD_RESERVE_PUSH;
            push_slot_reg <= '0;
            push_gen_reg  <= '0;
            pop_slot_reg  <= '0;
            pop_gen_reg   <= '0;
            disabled_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_fire)
            begin
                cmd_reg <= cmd.command;
            end
            if (exec_fire)
            begin
                push_slot_reg <= push_slot_next;
                push_gen_reg  <= push_gen_next;
                pop_slot_reg  <= pop_slot_next;
                pop_gen_reg   <= pop_gen_next;
                disabled_reg  <= disabled_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            status_reg  <= sts;
            ggen_reg    <= rqsr_pkg::gen_field_t'(grant_gen);
            gslot_reg   <= rqsr_pkg::slot_field_t'(grant_slot);
            length_reg  <= rqsr_pkg::length_t'(len_full);
            enabled_reg <= !disabled_next;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = status_reg;
    assign rsp.granted_generation = ggen_reg;
    assign rsp.granted_slot       = gslot_reg;
    assign rsp.length             = length_reg;
    assign rsp.enabled            = enabled_reg;

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> state_reg == FSM_EXEC)
        else $error("accepted command did not enter execution");

    a_exec_loads_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid_reg && state_reg == FSM_IDLE)
        else $error("completed command did not present a response");

    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == FSM_EXEC && init_done)
        else $error("slot write outside command execution");

    a_grant_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != rqsr_pkg::STS_OK |->
            ggen_reg == '0 && gslot_reg == '0)
        else $error("grant fields set on a non-granted response");

    a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done |-> state_reg == FSM_IDLE && !out_valid_reg)
        else $error("command activity during the clearing pass");

endmodule
